>>> rtl/fenwick_tree_prefix_sum_assert.svh
// Assertion macros shared by the prefix-sum tree modules
`ifndef FENWICK_TREE_PREFIX_SUM_ASSERT_SVH
`define FENWICK_TREE_PREFIX_SUM_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define FTPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked out of reset
`define FTPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/ftps_pkg.sv
// Shared types and constants for the prefix-sum tree
package ftps_pkg;

  localparam int SIZE_W = 11;
  localparam int POS_W = 11;
  localparam int DELTA_W = 32;
  localparam int SUM_W = 64;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic rd;
    logic exec;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_done;
    logic is_query;
  } dp_status_t;

endpackage

>>> rtl/ftps_ctrl.sv
// Sequencer for clearing, update climbs and query descents
module ftps_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  ftps_pkg::dp_status_t  status_i,
  output ftps_pkg::ctrl_cmd_t   cmd_o
);

  ftps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftps_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy = 1'b1;
    case (state_q)
      ftps_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ftps_pkg::ST_IDLE;
        end
      end
      ftps_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = ftps_pkg::ST_WALK;
        end
      end
      ftps_pkg::ST_WALK: begin
        if (status_i.walk_done) begin
          cmd_o.emit = status_i.is_query;
          state_d = ftps_pkg::ST_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = ftps_pkg::ST_EXEC;
        end
      end
      ftps_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = ftps_pkg::ST_WALK;
      end
      default: begin
        state_d = ftps_pkg::ST_IDLE;
      end
    endcase
  end

`include "fenwick_tree_prefix_sum_assert.svh"

  `FTPS_ASSERT_NXT(a_exec_after_read, clk_i, rst_ni, state_q == ftps_pkg::ST_EXEC, state_q == ftps_pkg::ST_WALK)
  `FTPS_ASSERT_IMP(a_exec_from_walk, clk_i, rst_ni, state_q == ftps_pkg::ST_EXEC, $past(cmd_o.rd))
  `FTPS_ASSERT_IMP(a_idle_not_busy, clk_i, rst_ni, cmd_o.load, !busy && start)

endmodule

>>> rtl/ftps_dp.sv
// Index walker, partial-sum memory, accumulator and size register
module ftps_dp #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ftps_pkg::ctrl_cmd_t                 cmd_i,
  output ftps_pkg::dp_status_t                status_o,
  input  logic                                cfg_valid_i,
  input  logic [ftps_pkg::SIZE_W-1:0]         cfg_data_i,
  input  logic                                func_i,
  input  logic [ftps_pkg::POS_W-1:0]          position_i,
  input  logic signed [ftps_pkg::DELTA_W-1:0] delta_i,
  output logic                                prefix_total_valid_o,
  output logic signed [ftps_pkg::SUM_W-1:0]   prefix_total_o
);

  localparam int AW = $clog2(MAX_POSITIONS);
  localparam int IW = $clog2(MAX_POSITIONS + 1) + 1;
  localparam int CW = (IW > ftps_pkg::SIZE_W) ? IW : ftps_pkg::SIZE_W;

  logic [ftps_pkg::SIZE_W-1:0] size_q;
  logic [AW-1:0]               clr_cnt_q;
  logic [IW-1:0]               idx_q;
  logic                        func_q;
  logic [ftps_pkg::SUM_W-1:0]  delta_q;
  logic [ftps_pkg::SUM_W-1:0]  acc_q;
  logic [ftps_pkg::SUM_W-1:0]  rd_data_q;
  logic                        res_valid_q;
  logic [ftps_pkg::SUM_W-1:0]  res_q;
  logic [ftps_pkg::SUM_W-1:0]  mem [MAX_POSITIONS];

  logic [CW-1:0]              size_ext;
  logic [CW-1:0]              max_ext;
  logic [CW-1:0]              eff_size;
  logic [CW-1:0]              pos_ext;
  logic [CW-1:0]              pos_cl;
  logic [IW-1:0]              idx_m1;
  logic [IW-1:0]              low_bit;
  logic [AW-1:0]              walk_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [ftps_pkg::SUM_W-1:0] wr_data;

  assign size_ext = CW'(size_q);
  assign max_ext = CW'(MAX_POSITIONS);
  assign eff_size = (size_ext > max_ext) ? max_ext : size_ext;
  assign pos_ext = CW'(position_i);
  assign pos_cl = (pos_ext > eff_size) ? eff_size : pos_ext;
  assign idx_m1 = idx_q - IW'(1);
  assign low_bit = idx_q & (~idx_q + IW'(1));
  assign walk_addr = idx_m1[AW-1:0];

  assign status_o.clr_last = (clr_cnt_q == AW'(MAX_POSITIONS - 1));
  assign status_o.is_query = (func_q == ftps_pkg::FUNC_QUERY);
  assign status_o.walk_done = (idx_q == '0) ||
                              ((func_q == ftps_pkg::FUNC_ADD) && (CW'(idx_q) > eff_size));

  assign wr_en = cmd_i.clear || (cmd_i.exec && (func_q == ftps_pkg::FUNC_ADD));
  assign wr_addr = cmd_i.clear ? clr_cnt_q : walk_addr;
  assign wr_data = cmd_i.clear ? '0 : (rd_data_q + delta_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[walk_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= ftps_pkg::SIZE_RESET;
      clr_cnt_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        size_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= IW'(pos_cl);
      func_q <= func_i;
      delta_q <= {{(ftps_pkg::SUM_W - ftps_pkg::DELTA_W){delta_i[ftps_pkg::DELTA_W-1]}},
                  delta_i};
      acc_q <= '0;
    end else if (cmd_i.exec) begin
      if (func_q == ftps_pkg::FUNC_QUERY) begin
        acc_q <= acc_q + rd_data_q;
        idx_q <= idx_q - low_bit;
      end else begin
        idx_q <= idx_q + low_bit;
      end
    end
    if (cmd_i.emit) begin
      res_q <= acc_q;
    end
  end

  assign prefix_total_valid_o = res_valid_q;
  assign prefix_total_o = res_q;

`include "fenwick_tree_prefix_sum_assert.svh"

  `FTPS_ASSERT_NXT(a_emit_strobe, clk_i, rst_ni, cmd_i.emit, prefix_total_valid_o)
  `FTPS_ASSERT_NXT(a_climb_up, clk_i, rst_ni, cmd_i.exec && (func_q == ftps_pkg::FUNC_ADD), idx_q > $past(idx_q))
  `FTPS_ASSERT_NXT(a_descend_down, clk_i, rst_ni, cmd_i.exec && (func_q == ftps_pkg::FUNC_QUERY), idx_q < $past(idx_q))

endmodule

>>> rtl/fenwick_tree_prefix_sum.sv
// Top level of the binary indexed tree prefix-sum engine
// An operation walks k entries (k <= log2(MAX_POSITIONS)+1), each with a memory read in
// ST_WALK, then an add or write back in ST_EXEC, and finishes in a last ST_WALK; busy throughout.
// A query result strobes in the first cycle with busy low.
// After reset the memory is zeroed one entry a cycle, with busy high until it is done.
// Results are not held: the receiver must take each strobe as it comes.
module fenwick_tree_prefix_sum #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ftps_pkg::SIZE_W-1:0]         cfg_data_i,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic [ftps_pkg::POS_W-1:0]          position_i,
  input  logic signed [ftps_pkg::DELTA_W-1:0] delta_i,
  output logic                                prefix_total_valid_o,
  output logic signed [ftps_pkg::SUM_W-1:0]   prefix_total_o
);

  ftps_pkg::ctrl_cmd_t  cmd;
  ftps_pkg::dp_status_t status;
  logic                 cfg_we;

  assign cfg_ready_o = !busy && !start;
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  ftps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ftps_dp #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_valid_i          (cfg_we),
    .cfg_data_i           (cfg_data_i),
    .func_i               (func_i),
    .position_i           (position_i),
    .delta_i              (delta_i),
    .prefix_total_valid_o (prefix_total_valid_o),
    .prefix_total_o       (prefix_total_o)
  );

endmodule

>>> tb/fenwick_tree_prefix_sum_tb.sv
// Self-checking testbench for the binary indexed tree prefix-sum engine
module fenwick_tree_prefix_sum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POS      = 1024;
  localparam int DRAIN_CYCLES = 32;
  localparam int STALL_LIMIT  = 4 * (MAX_POS + 64);
  localparam int PHASE_ITEMS  = 153;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [ftps_pkg::SIZE_W-1:0]         cfg_data_i;
  logic                                start;
  logic                                busy;
  logic                                func_i;
  logic [ftps_pkg::POS_W-1:0]          position_i;
  logic signed [ftps_pkg::DELTA_W-1:0] delta_i;
  logic                                prefix_total_valid_o;
  logic signed [ftps_pkg::SUM_W-1:0]   prefix_total_o;

  logic [ftps_pkg::SUM_W-1:0]  tree_sums [1:MAX_POS];
  logic [ftps_pkg::SIZE_W-1:0] size_setting;
  logic [ftps_pkg::SUM_W-1:0]  pending_totals [$];

  int fail_count    = 0;
  int add_count     = 0;
  int query_count   = 0;
  int checked_count = 0;
  int size_writes   = 0;
  int stall_cycles  = 0;
  bit burst_mode    = 1'b0;

  fenwick_tree_prefix_sum #(
    .MAX_POSITIONS(MAX_POS)
  ) DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .start               (start),
    .busy                (busy),
    .func_i              (func_i),
    .position_i          (position_i),
    .delta_i             (delta_i),
    .prefix_total_valid_o(prefix_total_valid_o),
    .prefix_total_o      (prefix_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int active_size();
    return (int'(size_setting) > MAX_POS) ? MAX_POS : int'(size_setting);
  endfunction

  function automatic void apply_to_tree(logic op, logic [ftps_pkg::POS_W-1:0] pos,
                                        logic signed [ftps_pkg::DELTA_W-1:0] d);
    int limit;
    int idx;
    logic [ftps_pkg::SUM_W-1:0] d_ext;
    logic [ftps_pkg::SUM_W-1:0] total;
    limit = active_size();
    idx = (int'(pos) > limit) ? limit : int'(pos);
    d_ext = {{(ftps_pkg::SUM_W-ftps_pkg::DELTA_W){d[ftps_pkg::DELTA_W-1]}}, d};
    if (op == ftps_pkg::FUNC_ADD) begin
      while (idx >= 1 && idx <= limit) begin
        tree_sums[idx] += d_ext;
        idx += idx & -idx;
      end
      add_count++;
    end else begin
      total = '0;
      while (idx >= 1) begin
        total += tree_sums[idx];
        idx -= idx & -idx;
      end
      pending_totals.insert(pending_totals.size(), total);
      query_count++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(15, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [ftps_pkg::POS_W-1:0] pick_position(int eff);
    int r;
    r = $urandom_range(99);
    if (eff == 0) return ftps_pkg::POS_W'($urandom_range(2047));
    if (r < 8) return '0;
    if (r < 18) return ftps_pkg::POS_W'($urandom_range(2047, eff));
    if (r < 24) return ftps_pkg::POS_W'(eff);
    return ftps_pkg::POS_W'($urandom_range(eff, 1));
  endfunction

  function automatic logic signed [ftps_pkg::DELTA_W-1:0] pick_delta();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'sh8000_0000;
    if (r < 20) return 32'sh7fff_ffff;
    if (r < 28) return ftps_pkg::DELTA_W'($urandom_range(16)) - 32'sd8;
    return ftps_pkg::DELTA_W'($urandom);
  endfunction

  task automatic report_mismatch(string what, logic signed [ftps_pkg::SUM_W-1:0] want,
                                 logic signed [ftps_pkg::SUM_W-1:0] got);
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  // hold the request until busy is low at a rising edge
  task automatic send_request(logic op, logic [ftps_pkg::POS_W-1:0] pos,
                              logic signed [ftps_pkg::DELTA_W-1:0] d);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start      <= 1'b1;
    func_i     <= op;
    position_i <= pos;
    delta_i    <= d;
    do @(posedge clk_i); while (busy);
    apply_to_tree(op, pos, d);
  endtask

  task automatic settle_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tree_size(logic [ftps_pkg::SIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_setting = value;
    size_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_request(ftps_pkg::FUNC_QUERY, 11'd0, 32'sd0);
    send_request(ftps_pkg::FUNC_QUERY, 11'd1024, 32'sd0);
    send_request(ftps_pkg::FUNC_QUERY, 11'd2047, 32'sd0);
  endtask

  task automatic test_field_extremes();
    send_request(ftps_pkg::FUNC_ADD, 11'd1, 32'sh7fff_ffff);
    send_request(ftps_pkg::FUNC_ADD, 11'd1024, 32'sh8000_0000);
    send_request(ftps_pkg::FUNC_ADD, 11'd2047, -32'sd1);
    send_request(ftps_pkg::FUNC_ADD, 11'd0, 32'sd12345);
    send_request(ftps_pkg::FUNC_ADD, 11'd683, 32'sd5);
    send_request(ftps_pkg::FUNC_QUERY, 11'd0, 32'shffff_ffff);
    send_request(ftps_pkg::FUNC_QUERY, 11'd1, 32'sh7fff_ffff);
    send_request(ftps_pkg::FUNC_QUERY, 11'd683, 32'sh5555_aaaa);
    send_request(ftps_pkg::FUNC_QUERY, 11'd1023, 32'sd0);
    send_request(ftps_pkg::FUNC_QUERY, 11'd1024, 32'sd0);
    send_request(ftps_pkg::FUNC_QUERY, 11'd2047, 32'sd0);
  endtask

  task automatic test_size_settings();
    settle_idle();
    write_tree_size(11'd1);
    send_request(ftps_pkg::FUNC_ADD, 11'd5, 32'sd7);
    send_request(ftps_pkg::FUNC_QUERY, 11'd1024, 32'sd0);
    settle_idle();
    write_tree_size(11'd0);
    send_request(ftps_pkg::FUNC_ADD, 11'd3, 32'sd9);
    send_request(ftps_pkg::FUNC_QUERY, 11'd3, 32'sd0);
    settle_idle();
    write_tree_size(11'd2047);
    send_request(ftps_pkg::FUNC_QUERY, 11'd2047, 32'sd0);
    settle_idle();
    write_tree_size(11'd2);
    send_request(ftps_pkg::FUNC_QUERY, 11'd2, 32'sd0);
  endtask

  task automatic run_random_phase(logic [ftps_pkg::SIZE_W-1:0] size_value, int items);
    int eff;
    logic op;
    settle_idle();
    write_tree_size(size_value);
    eff = active_size();
    for (int n = 0; n < items; n++) begin
      if (n % 64 == 0) burst_mode = ($urandom_range(3) == 0);
      op = ($urandom_range(1) == 1) ? ftps_pkg::FUNC_QUERY : ftps_pkg::FUNC_ADD;
      send_request(op, pick_position(eff), pick_delta());
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_random_mix();
    logic [ftps_pkg::SIZE_W-1:0] sizes [10];
    sizes = '{11'd1024, 11'd37, 11'd2047, 11'd1, 11'd600,
              11'd0, 11'd2, 11'd1000, 11'd1023, 11'd16};
    foreach (sizes[k]) run_random_phase(sizes[k], PHASE_ITEMS);
  endtask

  always @(posedge clk_i) begin : check_totals
    logic [ftps_pkg::SUM_W-1:0] want;
    if (rst_ni && prefix_total_valid_o) begin
      if (pending_totals.size() == 0) begin
        report_mismatch("result with no query outstanding", '0, prefix_total_o);
      end else begin
        want = pending_totals.pop_front();
        checked_count++;
        if (prefix_total_o !== want) report_mismatch("prefix_total", want, prefix_total_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || (cfg_valid_i && cfg_ready_o) ||
        prefix_total_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: %0d cycles without a handshake", $realtime, stall_cycles);
      $display("fenwick_tree_prefix_sum verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    func_i      = ftps_pkg::FUNC_ADD;
    position_i  = '0;
    delta_i     = '0;
    foreach (tree_sums[k]) tree_sums[k] = '0;
    size_setting = ftps_pkg::SIZE_RESET;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_field_extremes();
    test_size_settings();
    test_random_mix();
    settle_idle();

    $display("Summary: %0d point adds and %0d prefix queries over %0d tree size writes",
             add_count, query_count, size_writes);
    $display("Summary: %0d totals compared, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("fenwick_tree_prefix_sum verification clean");
    end else begin
      $display("fenwick_tree_prefix_sum verification failed");
    end
    $finish;
  end

endmodule
